>>> hdl/thrl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thrl_pkg
// Record layout, operation codes, result bundle and timestamp check for the
// timestamped history ring log.
// ----------------------------------------------------------------------------
package thrl_pkg;

    localparam logic [1:0] OP_SAVE  = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    localparam int SLOT_W = 6;

    localparam logic [7:0] YEAR_MAX   = 8'd99;
    localparam logic [7:0] MONTH_MAX  = 8'd12;
    localparam logic [7:0] DAY_MAX    = 8'd31;
    localparam logic [7:0] HOUR_MAX   = 8'd23;
    localparam logic [7:0] MINUTE_MAX = 8'd59;

    typedef struct packed {
        logic [31:0] flow;
        logic [7:0]  year;
        logic [7:0]  month;
        logic [7:0]  day;
        logic [7:0]  hour;
        logic [7:0]  minute;
    } t_rec;

    typedef struct packed {
        logic              done;
        t_rec              rec;
        logic [SLOT_W-1:0] slot;
    } t_res;

    function automatic logic stamp_ok(input t_rec r);
        return (r.year <= YEAR_MAX)
            && (r.month != 8'd0) && (r.month <= MONTH_MAX)
            && (r.day != 8'd0) && (r.day <= DAY_MAX)
            && (r.hour <= HOUR_MAX)
            && (r.minute <= MINUTE_MAX);
    endfunction

endpackage

>>> hdl/thrl_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thrl_if
// Valid/ready channels for log commands and log results.
// ----------------------------------------------------------------------------
interface thrl_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  op;
    logic [31:0] flow_value;
    logic [7:0]  year_in;
    logic [7:0]  month_in;
    logic [7:0]  day_in;
    logic [7:0]  hour_in;
    logic [7:0]  minute_in;

    modport source (output valid, op, flow_value, year_in, month_in, day_in,
                    hour_in, minute_in, input ready);
    modport sink   (input valid, op, flow_value, year_in, month_in, day_in,
                    hour_in, minute_in, output ready);
endinterface

interface thrl_out_if;
    logic        valid;
    logic        ready;
    logic        done_flag;
    logic [31:0] flow_out;
    logic [7:0]  year_out;
    logic [7:0]  month_out;
    logic [7:0]  day_out;
    logic [7:0]  hour_out;
    logic [7:0]  minute_out;
    logic [5:0]  slot_out;

    modport source (output valid, done_flag, flow_out, year_out, month_out,
                    day_out, hour_out, minute_out, slot_out, input ready);
    modport sink   (input valid, done_flag, flow_out, year_out, month_out,
                    day_out, hour_out, minute_out, slot_out, output ready);
endinterface

>>> hdl/thrl_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thrl_store
// Record memory with one registered read port, one write port and per-slot
// valid bits; a slot that is not valid reads as an all-zero record.
// ----------------------------------------------------------------------------
module thrl_store
    import thrl_pkg::*;
#(
    parameter int LOG_DEPTH = 64,
    parameter int IDX_W     = 6
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [IDX_W-1:0] i_rd_addr,
    output t_rec             o_rd_rec,
    input  logic             i_wr_en,
    input  logic             i_wr_clr,
    input  logic [IDX_W-1:0] i_wr_addr,
    input  t_rec             i_wr_rec
);

    t_rec           r_mem [LOG_DEPTH];
    logic           r_valid [LOG_DEPTH];
    t_rec           r_rd_data;
    logic           r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_rec;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < LOG_DEPTH; k++) begin
                r_valid[k] <= 1'b0;
            end
            r_rd_vld <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end else if (i_wr_clr) begin
                r_valid[i_wr_addr] <= 1'b0;
            end
            r_rd_vld <= r_valid[i_rd_addr];
        end
    end

    assign o_rd_rec = r_rd_vld ? r_rd_data : '0;

endmodule

>>> hdl/thrl_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thrl_seq
// Command sequencer: fetches one record per cycle during a read scan, runs it
// through the shared flow/timestamp compare and steers memory writes and position updates.
// ----------------------------------------------------------------------------
module thrl_seq
    import thrl_pkg::*;
#(
    parameter int LOG_DEPTH = 64,
    parameter int IDX_W     = 6
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    thrl_in_if.sink          i_cmd,
    output logic [IDX_W-1:0] o_rd_addr,
    input  t_rec             i_rd_rec,
    output logic             o_wr_en,
    output logic             o_wr_clr,
    output logic [IDX_W-1:0] o_wr_addr,
    output t_rec             o_wr_rec,
    output logic             o_res_vld,
    input  logic             i_res_rdy,
    output t_res             o_res
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_LOOK = 2'd1;
    localparam logic [1:0] ST_PUSH = 2'd2;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(LOG_DEPTH - 1);

    logic [1:0]       r_state, n_state;
    logic [IDX_W-1:0] r_wpos, n_wpos;
    logic [IDX_W-1:0] r_rpos, n_rpos;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic [1:0]       r_op;
    t_rec             r_cmd, n_cmd;
    t_res             r_res, n_res;

    logic             accept;
    logic [IDX_W-1:0] idx_inc;
    logic [IDX_W-1:0] wpos_inc;
    logic             flow_hit;
    logic             stamp_hit;

    function automatic logic [SLOT_W-1:0] to_slot(input logic [IDX_W-1:0] idx);
        logic [IDX_W+SLOT_W-1:0] ext;
        ext = {{SLOT_W{1'b0}}, idx};
        return ext[SLOT_W-1:0];
    endfunction

    assign accept    = i_cmd.valid && i_cmd.ready;
    assign i_cmd.ready = (r_state == ST_IDLE);

    assign idx_inc   = (r_idx == LAST_IDX) ? '0 : r_idx + 1'b1;
    assign wpos_inc  = (r_wpos == LAST_IDX) ? '0 : r_wpos + 1'b1;

    // shared compare unit on the record fetched for r_idx
    assign flow_hit  = (i_rd_rec.flow == r_cmd.flow);
    assign stamp_hit = stamp_ok(i_rd_rec);

    always_comb begin
        n_state   = r_state;
        n_wpos    = r_wpos;
        n_rpos    = r_rpos;
        n_idx     = r_idx;
        n_cmd     = r_cmd;
        n_res     = r_res;
        o_rd_addr = r_idx;
        o_wr_en   = 1'b0;
        o_wr_clr  = 1'b0;
        o_wr_addr = r_rpos;
        o_wr_rec  = r_cmd;

        unique case (r_state)
            ST_IDLE: begin
                o_rd_addr = (i_cmd.op == OP_SAVE) ? r_wpos : r_rpos;
                if (accept) begin
                    n_idx      = o_rd_addr;
                    n_cmd.flow   = i_cmd.flow_value;
                    n_cmd.year   = i_cmd.year_in;
                    n_cmd.month  = i_cmd.month_in;
                    n_cmd.day    = i_cmd.day_in;
                    n_cmd.hour   = i_cmd.hour_in;
                    n_cmd.minute = i_cmd.minute_in;
                    n_state    = ST_LOOK;
                end
            end
            ST_LOOK: begin
                n_res   = '0;
                n_state = ST_PUSH;
                unique case (r_op)
                    OP_SAVE: begin
                        if (!flow_hit) begin
                            o_wr_en        = 1'b1;
                            o_wr_addr      = wpos_inc;
                            n_wpos         = wpos_inc;
                            n_res.done     = 1'b1;
                            n_res.slot     = to_slot(wpos_inc);
                        end
                    end
                    OP_READ: begin
                        if (stamp_hit) begin
                            n_rpos     = r_idx;
                            n_res.done = 1'b1;
                            n_res.rec  = i_rd_rec;
                            n_res.slot = to_slot(r_idx);
                        end else if (r_idx != r_wpos) begin
                            // advance the scan, fetching the next slot
                            n_idx     = idx_inc;
                            o_rd_addr = idx_inc;
                            n_state   = ST_LOOK;
                        end
                    end
                    OP_CLEAR: begin
                        o_wr_clr   = 1'b1;
                        n_res.done = 1'b1;
                        n_res.slot = to_slot(r_rpos);
                    end
                    default: begin
                    end
                endcase
            end
            ST_PUSH: begin
                if (i_res_rdy) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_res_vld = (r_state == ST_PUSH);
    assign o_res     = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_wpos  <= '0;
            r_rpos  <= '0;
        end else begin
            r_state <= n_state;
            r_wpos  <= n_wpos;
            r_rpos  <= n_rpos;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        r_cmd <= n_cmd;
        r_res <= n_res;
        if (accept) begin
            r_op <= i_cmd.op;
        end
    end

endmodule

>>> hdl/timestamped_history_ring_log.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timestamped_history_ring_log
// Ring of timestamped flow records with save, read-next-valid and clear.
// ----------------------------------------------------------------------------
// Save and clear: the command passes the look-up and result states of the sequencer,
// then the output register. Read: the look-up state repeats for each extra slot scanned;
// the scan fetches one record per cycle through the single memory read port.
// The sequencer is ready for a new command in the cycle after its result leaves.
// Synchronous active-low reset empties the ring and zeroes both positions.
module timestamped_history_ring_log
    import thrl_pkg::*;
#(
    parameter int LOG_DEPTH = 64
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    thrl_in_if.sink  i_in,
    thrl_out_if.source o_out
);

    localparam int IDX_W = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;

    logic [IDX_W-1:0] rd_addr;
    t_rec             rd_rec;
    logic             wr_en;
    logic             wr_clr;
    logic [IDX_W-1:0] wr_addr;
    t_rec             wr_rec;
    logic             res_vld;
    logic             res_rdy;
    t_res             res;

    logic             r_out_vld;
    t_res             r_out;

    thrl_store #(
        .LOG_DEPTH (LOG_DEPTH),
        .IDX_W     (IDX_W)
    ) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_addr (rd_addr),
        .o_rd_rec  (rd_rec),
        .i_wr_en   (wr_en),
        .i_wr_clr  (wr_clr),
        .i_wr_addr (wr_addr),
        .i_wr_rec  (wr_rec)
    );

    thrl_seq #(
        .LOG_DEPTH (LOG_DEPTH),
        .IDX_W     (IDX_W)
    ) u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (i_in),
        .o_rd_addr (rd_addr),
        .i_rd_rec  (rd_rec),
        .o_wr_en   (wr_en),
        .o_wr_clr  (wr_clr),
        .o_wr_addr (wr_addr),
        .o_wr_rec  (wr_rec),
        .o_res_vld (res_vld),
        .i_res_rdy (res_rdy),
        .o_res     (res)
    );

    // output register: load when empty or draining this cycle
    assign res_rdy = !r_out_vld || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (res_rdy) begin
            r_out_vld <= res_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_rdy && res_vld) begin
            r_out <= res;
        end
    end

    assign o_out.valid      = r_out_vld;
    assign o_out.done_flag  = r_out.done;
    assign o_out.flow_out   = r_out.rec.flow;
    assign o_out.year_out   = r_out.rec.year;
    assign o_out.month_out  = r_out.rec.month;
    assign o_out.day_out    = r_out.rec.day;
    assign o_out.hour_out   = r_out.rec.hour;
    assign o_out.minute_out = r_out.rec.minute;
    assign o_out.slot_out   = r_out.slot;

endmodule

>>> tb/sv/thrl_log_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thrl_log_checker
// Watches the command and result channels of the history ring log, keeps a
// shadow copy of the record ring and both positions, predicts the result of
// every accepted command and compares each result beat with the oldest
// prediction, field by field.
// ----------------------------------------------------------------------------
module thrl_log_checker
    import thrl_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  logic i_clk,
    input  logic i_rst_n,
    thrl_in_if   i_cmd,
    thrl_out_if  i_res,
    output int   o_errors,
    output int   o_pending
);

    t_rec ring [DEPTH];
    int   wr_pos;
    int   rd_pos;
    int   err_cnt;
    t_res pending_q [$];

    function automatic bit stamp_valid(input t_rec r);
        return r.year <= YEAR_MAX
            && r.month >= 8'd1 && r.month <= MONTH_MAX
            && r.day >= 8'd1 && r.day <= DAY_MAX
            && r.hour <= HOUR_MAX
            && r.minute <= MINUTE_MAX;
    endfunction

    // Apply one command to the shadow ring and return the result it gives.
    task automatic log_apply(input logic [1:0] op, input t_rec cmd, output t_res res);
        int  idx;
        int  n;
        bit  hunting;
        res = '0;
        if (wr_pos >= DEPTH) begin
            wr_pos = 0;
        end
        case (op)
            OP_SAVE: begin
                if (ring[wr_pos].flow != cmd.flow) begin
                    wr_pos = (wr_pos == DEPTH - 1) ? 0 : wr_pos + 1;
                    ring[wr_pos] = cmd;
                    res.done = 1'b1;
                    res.slot = wr_pos[SLOT_W-1:0];
                end
            end
            OP_READ: begin
                if (rd_pos >= DEPTH) begin
                    rd_pos = 0;
                end
                idx = rd_pos;
                hunting = 1'b1;
                n = 0;
                while (hunting && n < DEPTH) begin
                    if (stamp_valid(ring[idx])) begin
                        // park on the record found
                        rd_pos = idx;
                        res.done = 1'b1;
                        res.rec = ring[idx];
                        res.slot = idx[SLOT_W-1:0];
                        hunting = 1'b0;
                    end else if (idx == wr_pos) begin
                        hunting = 1'b0;
                    end else begin
                        idx = (idx == DEPTH - 1) ? 0 : idx + 1;
                    end
                    n++;
                end
            end
            OP_CLEAR: begin
                idx = (rd_pos < DEPTH) ? rd_pos : 0;
                ring[idx] = '0;
                res.done = 1'b1;
                res.slot = idx[SLOT_W-1:0];
            end
            default: ;
        endcase
    endtask

    always @(posedge i_clk) begin
        t_rec cmd_rec;
        t_res want;
        t_res got;
        if (!i_rst_n) begin
            for (int s = 0; s < DEPTH; s++) begin
                ring[s] = '0;
            end
            wr_pos = 0;
            rd_pos = 0;
            err_cnt = 0;
            pending_q.delete();
            o_errors <= 0;
            o_pending <= 0;
        end else begin
            if (i_cmd.valid && i_cmd.ready) begin
                cmd_rec.flow   = i_cmd.flow_value;
                cmd_rec.year   = i_cmd.year_in;
                cmd_rec.month  = i_cmd.month_in;
                cmd_rec.day    = i_cmd.day_in;
                cmd_rec.hour   = i_cmd.hour_in;
                cmd_rec.minute = i_cmd.minute_in;
                log_apply(i_cmd.op, cmd_rec, want);
                pending_q.push_back(want);
            end
            if (i_res.valid && i_res.ready) begin
                got.done       = i_res.done_flag;
                got.rec.flow   = i_res.flow_out;
                got.rec.year   = i_res.year_out;
                got.rec.month  = i_res.month_out;
                got.rec.day    = i_res.day_out;
                got.rec.hour   = i_res.hour_out;
                got.rec.minute = i_res.minute_out;
                got.slot       = i_res.slot_out;
                if (pending_q.size() == 0) begin
                    err_cnt++;
                    if (err_cnt <= 10) begin
                        $display("%0t: result beat with nothing pending: done=%0d slot=%0d",
                                 $time, got.done, got.slot);
                    end
                end else begin
                    want = pending_q.pop_front();
                    if (got.done !== want.done || got.rec.flow !== want.rec.flow
                        || got.rec.year !== want.rec.year
                        || got.rec.month !== want.rec.month
                        || got.rec.day !== want.rec.day
                        || got.rec.hour !== want.rec.hour
                        || got.rec.minute !== want.rec.minute
                        || got.slot !== want.slot) begin
                        err_cnt++;
                        if (err_cnt <= 10) begin
                            $display("%0t: exp done=%0d flow=%h ts=%0d/%0d/%0d %0d:%0d slot=%0d",
                                     $time, want.done, want.rec.flow, want.rec.year,
                                     want.rec.month, want.rec.day, want.rec.hour,
                                     want.rec.minute, want.slot);
                            $display("%0t: got done=%0d flow=%h ts=%0d/%0d/%0d %0d:%0d slot=%0d",
                                     $time, got.done, got.rec.flow, got.rec.year,
                                     got.rec.month, got.rec.day, got.rec.hour,
                                     got.rec.minute, got.slot);
                        end
                    end
                end
            end
            o_errors <= err_cnt;
            o_pending <= pending_q.size();
        end
    end

endmodule

>>> tb/sv/timestamped_history_ring_log_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timestamped_history_ring_log_tb
// Drives save, read, clear and undefined commands into the history ring log:
// a directed walk over timestamp limits, duplicates, scans and clears, then
// random traffic with random gaps on both channels and one long result stall.
// The checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module timestamped_history_ring_log_tb;
    import thrl_pkg::*;

    localparam int DEPTH       = 64;
    localparam int RAND_CMDS   = 450;
    localparam int CYCLE_LIMIT = 200000;

    // op code outside the defined set
    localparam logic [1:0] OP_UNUSED = 2'd3;

    logic i_clk;
    logic i_rst_n;
    logic long_hold;
    logic tx_burst;
    logic rx_burst;
    logic [31:0] last_flow;
    int   cmd_count;
    int   cycle_cnt = 0;
    int   errors;
    int   pending;

    thrl_in_if  cmd_if ();
    thrl_out_if res_if ();

    timestamped_history_ring_log #(
        .LOG_DEPTH(DEPTH)
    ) i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (cmd_if),
        .o_out  (res_if)
    );

    thrl_log_checker #(
        .DEPTH(DEPTH)
    ) i_checker (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd_if),
        .i_res    (res_if),
        .o_errors (errors),
        .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("timestamped_history_ring_log: mismatch");
            $finish;
        end
    end

    // Offer one command beat after a random gap and hold it until taken.
    task automatic send_cmd(input logic [1:0] op, input t_rec r);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            cmd_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        cmd_if.valid      <= 1'b1;
        cmd_if.op         <= op;
        cmd_if.flow_value <= r.flow;
        cmd_if.year_in    <= r.year;
        cmd_if.month_in   <= r.month;
        cmd_if.day_in     <= r.day;
        cmd_if.hour_in    <= r.hour;
        cmd_if.minute_in  <= r.minute;
        @(posedge i_clk);
        while (!cmd_if.ready) @(posedge i_clk);
        if (op == OP_SAVE) begin
            last_flow = r.flow;
        end
        cmd_count++;
    endtask

    // Mostly well-formed stamps; the rest break one field or are pure noise.
    function automatic t_rec random_rec();
        t_rec r;
        int   kind;
        r.flow   = $urandom();
        r.year   = 8'($urandom_range(0, 99));
        r.month  = 8'($urandom_range(1, 12));
        r.day    = 8'($urandom_range(1, 31));
        r.hour   = 8'($urandom_range(0, 23));
        r.minute = 8'($urandom_range(0, 59));
        kind = $urandom_range(0, 99);
        if (kind >= 85) begin
            r.year   = 8'($urandom());
            r.month  = 8'($urandom());
            r.day    = 8'($urandom());
            r.hour   = 8'($urandom());
            r.minute = 8'($urandom());
        end else if (kind >= 70) begin
            case ($urandom_range(0, 6))
                0: r.year   = 8'($urandom_range(100, 255));
                1: r.month  = 8'd0;
                2: r.month  = 8'($urandom_range(13, 255));
                3: r.day    = 8'd0;
                4: r.day    = 8'($urandom_range(32, 255));
                5: r.hour   = 8'($urandom_range(24, 255));
                default: r.minute = 8'($urandom_range(60, 255));
            endcase
        end
        return r;
    endfunction

    // Result side: random wait per beat, bursts with none, one long hold.
    initial begin
        int gap;
        int beats;
        gap = 0;
        beats = 0;
        rx_burst = 1'b0;
        res_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (res_if.valid && res_if.ready) begin
                beats++;
                if (beats % 40 == 0) begin
                    rx_burst = ($urandom_range(0, 3) == 0);
                end
                gap = rx_burst ? 0 : $urandom_range(0, 5);
            end else if (gap > 0) begin
                gap--;
            end
            res_if.ready <= i_rst_n && (gap == 0) && !long_hold;
        end
    end

    // Hold off results long enough for the command side to back up.
    initial begin
        long_hold = 1'b0;
        wait (cmd_count >= 200);
        @(posedge i_clk);
        long_hold <= 1'b1;
        repeat (300) @(posedge i_clk);
        long_hold <= 1'b0;
    end

    initial begin
        t_rec rec;
        int   pick;
        cmd_count = 0;
        last_flow = '0;
        tx_burst = 1'b0;
        i_rst_n = 1'b0;
        cmd_if.valid      = 1'b0;
        cmd_if.op         = OP_SAVE;
        cmd_if.flow_value = '0;
        cmd_if.year_in    = '0;
        cmd_if.month_in   = '0;
        cmd_if.day_in     = '0;
        cmd_if.hour_in    = '0;
        cmd_if.minute_in  = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // read of an empty ring, duplicate of the zero flow, clear at slot 0
        send_cmd(OP_READ,  '0);
        send_cmd(OP_SAVE,  {32'h0000_0000, 8'd20, 8'd5, 8'd5, 8'd5, 8'd5});
        send_cmd(OP_CLEAR, '0);
        // stamp limits, duplicate save, one broken field each
        send_cmd(OP_SAVE,  {32'hFFFF_FFFF, 8'd99, 8'd12, 8'd31, 8'd23, 8'd59});
        send_cmd(OP_SAVE,  {32'hFFFF_FFFF, 8'd0, 8'd1, 8'd1, 8'd0, 8'd0});
        send_cmd(OP_SAVE,  {32'h0000_0001, 8'd0, 8'd1, 8'd1, 8'd0, 8'd0});
        send_cmd(OP_SAVE,  {32'h0000_0002, 8'd100, 8'd6, 8'd15, 8'd12, 8'd30});
        send_cmd(OP_SAVE,  {32'h0000_0003, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF});
        send_cmd(OP_SAVE,  {32'h0000_0004, 8'd10, 8'd0, 8'd15, 8'd12, 8'd30});
        send_cmd(OP_SAVE,  {32'h0000_0005, 8'd10, 8'd13, 8'd15, 8'd12, 8'd30});
        send_cmd(OP_SAVE,  {32'h0000_0006, 8'd10, 8'd6, 8'd0, 8'd12, 8'd30});
        send_cmd(OP_SAVE,  {32'h0000_0007, 8'd10, 8'd6, 8'd32, 8'd12, 8'd30});
        send_cmd(OP_SAVE,  {32'h0000_0008, 8'd10, 8'd6, 8'd15, 8'd24, 8'd30});
        send_cmd(OP_SAVE,  {32'h0000_0009, 8'd10, 8'd6, 8'd15, 8'd12, 8'd60});
        // find, find again, clear, scan on, a scan that runs dry, then an undefined op, a save and a read
        send_cmd(OP_READ,  '0);
        send_cmd(OP_READ,  '0);
        send_cmd(OP_CLEAR, '0);
        send_cmd(OP_READ,  '0);
        send_cmd(OP_CLEAR, '0);
        send_cmd(OP_READ,  '0);
        send_cmd(OP_UNUSED, {32'hA5A5_5A5A, 8'd1, 8'd2, 8'd3, 8'd4, 8'd5});
        send_cmd(OP_SAVE,  {32'h8000_0000, 8'd50, 8'd7, 8'd20, 8'd11, 8'd45});
        send_cmd(OP_READ,  '0);

        for (int k = 0; k < RAND_CMDS; k++) begin
            if (k % 40 == 0) begin
                tx_burst = ($urandom_range(0, 3) == 0);
            end
            rec = random_rec();
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                case ($urandom_range(0, 19))
                    0, 1: rec.flow = last_flow;
                    2:    rec.flow = '0;
                    3:    rec.flow = '1;
                    default: ;
                endcase
                send_cmd(OP_SAVE, rec);
            end else if (pick < 78) begin
                send_cmd(OP_READ, rec);
            end else if (pick < 98) begin
                send_cmd(OP_CLEAR, rec);
            end else begin
                send_cmd(OP_UNUSED, rec);
            end
        end
        cmd_if.valid <= 1'b0;

        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("timestamped_history_ring_log: match");
        end else begin
            $display("timestamped_history_ring_log: mismatch");
        end
        $finish;
    end

endmodule
